/* sv/bie_pkg.sv */
// Shared constants, types and index helpers for the bytecode instruction executor.
package bie_pkg;

	// Field and state widths
	localparam int WORD_W = 32;
	localparam int PC_W   = 12;
	localparam int LEN_W  = 13;
	localparam int IMM_W  = 20;
	localparam int OP_W   = 4;
	localparam int FLD_W  = 8;

	// Register memory geometry
	localparam int MEM_DEPTH = 256;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int FLD_VALS  = 1 << FLD_W;

	// Decoupling queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Reset value of the program length register
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(7);

	// Opcodes as found in the instruction word
	localparam logic [OP_W-1:0] OPC_LOAD  = 4'd0;
	localparam logic [OP_W-1:0] OPC_ADD   = 4'd1;
	localparam logic [OP_W-1:0] OPC_JMPNE = 4'd2;
	localparam logic [OP_W-1:0] OPC_PRINT = 4'd3;
	localparam logic [OP_W-1:0] OPC_RET   = 4'd4;

	// Classified operation carried through the queue
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] KIND_NOP   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADD   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_JMPNE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PRINT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RET   = 3'd5;

	// Decoded instruction; C index and jump target come from the low bits of imm
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MEM_AW-1:0] a;
		logic [MEM_AW-1:0] b;
		logic [MEM_AW-1:0] c;
		logic [IMM_W-1:0]  imm;
	} instr_t;

	// Operand field to memory index map, folded at elaboration
	typedef logic [MEM_AW-1:0] idx_map_t [FLD_VALS];

	function automatic idx_map_t idx_map_init();
		idx_map_t m;
		for (int i = 0; i < FLD_VALS; i++) begin
			m[i] = MEM_AW'(i % MEM_DEPTH);
		end
		return m;
	endfunction

	localparam idx_map_t IDX_MAP = idx_map_init();

	function automatic logic [MEM_AW-1:0] mem_index(input logic [FLD_W-1:0] f);
		return IDX_MAP[f];
	endfunction

endpackage

/* sv/bie_ifs.sv */
// Valid/ready channel interfaces for instruction items and result items.
interface bie_cmd_if;
	import bie_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink   (input valid, input instruction_word, output ready);
endinterface

interface bie_res_if;
	import bie_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [PC_W-1:0]          next_pc;
	logic                     print_valid;
	logic signed [WORD_W-1:0] print_value;
	logic                     run_done;

	modport source (output valid, output next_pc, output print_valid, output print_value,
			output run_done, input ready);
	modport sink   (input valid, input next_pc, input print_valid, input print_value,
			input run_done, output ready);
endinterface

/* sv/bytecode_instruction_executor.sv */
// Bytecode instruction executor: 32-bit instruction words in, one result per word out.
//
// cmd carries instruction words fetched at the current pc; res returns for each
// word the next pc to fetch, a print flag and value, and the end-of-run flag.
// cfg_we/cfg_wdata write the program length (reset value 7).
// A word accepted from cmd sits in a two-entry queue; when it is popped, the
// register memory is read on two ports into the execute stage, and when that
// stage fires, the word is executed, written back and its result is loaded
// into the output register. One item per cycle is sustained while res is not
// stalled, supported by the program counter loop and the memory write-to-read bypass.
// Reset clears the pc to zero and marks all 256 memory words unwritten, so
// they read as zero at once; no clearing pass is run.
// When res is stalled the result register holds, the execute stage and queue
// fill behind it, and cmd.ready drops once the queue is full.
// After a run ends the pc restarts at zero; memory contents are kept.
module bytecode_instruction_executor (
	input  logic                      clk,
	input  logic                      arst_n,
	bie_cmd_if.sink                   cmd,
	bie_res_if.source                 res,
	input  logic                      cfg_we,
	input  logic [bie_pkg::LEN_W-1:0] cfg_wdata
);
	import bie_pkg::*;

	logic   head_vld;
	instr_t head;
	logic   pop;

	bie_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.pop      (pop),
		.head_vld (head_vld),
		.head     (head)
	);

	bie_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

	// Pop only from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld)
		else $error("pop from empty queue");

	// A full queue never reports empty
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> head_vld)
		else $error("queue full but no head item");

	// A queued item that is not popped is still there next cycle
	a_head_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(head_vld && !pop && !cmd.valid) |=> head_vld)
		else $error("queued item lost");

	// Non-print results carry a zero value
	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.print_valid) |-> (res.print_value == '0))
		else $error("print value without print");

endmodule

/* sv/bie_front.sv */
// Front end: accepts instruction items, decodes them and queues them for the back end.
module bie_front (
	input  logic           clk,
	input  logic           arst_n,
	bie_cmd_if.sink        cmd,
	input  logic           pop,
	output logic           head_vld,
	output bie_pkg::instr_t head
);
	import bie_pkg::*;

	logic [Q_CW-1:0] cnt_q;
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	instr_t          q_mem [Q_DEPTH];
	instr_t          dec;
	logic            push;

	// Field extraction and opcode classification
	always_comb begin
		dec.a   = mem_index(cmd.instruction_word[31:24]);
		dec.b   = mem_index(cmd.instruction_word[23:16]);
		dec.c   = mem_index(cmd.instruction_word[11:4]);
		dec.imm = cmd.instruction_word[23:4];
		case (cmd.instruction_word[OP_W-1:0])
			OPC_LOAD:  dec.kind = KIND_LOAD;
			OPC_ADD:   dec.kind = KIND_ADD;
			OPC_JMPNE: dec.kind = KIND_JMPNE;
			OPC_PRINT: dec.kind = KIND_PRINT;
			OPC_RET:   dec.kind = KIND_RET;
			default:   dec.kind = KIND_NOP;
		endcase
	end

	assign cmd.ready = (cnt_q != Q_CW'(Q_DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign head_vld  = (cnt_q != '0);
	assign head      = q_mem[rptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= dec;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr_q + Q_AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + Q_CW'(1);
				2'b01:   cnt_q <= cnt_q - Q_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/bie_back.sv */
// Back end: register memory read, execute, program counter and result register.
module bie_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_vld,
	input  bie_pkg::instr_t          head,
	output logic                     pop,
	input  logic                     cfg_we,
	input  logic [bie_pkg::LEN_W-1:0] cfg_wdata,
	bie_res_if.source                res
);
	import bie_pkg::*;

	// Register memory and its written flags
	logic [WORD_W-1:0]    mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] ent_vld_q;

	// Execute stage
	logic              vld_s2;
	instr_t            item_s2;
	logic [WORD_W-1:0] mem_rd1_s2, mem_rd2_s2;
	logic              ent1_s2, ent2_s2;
	logic              byp1_s2, byp2_s2;
	logic [WORD_W-1:0] bypd_s2;

	logic [PC_W-1:0]  pc_q;
	logic [LEN_W-1:0] prog_len_q;

	// Result register
	logic              out_vld_q;
	logic [PC_W-1:0]   out_pc_q;
	logic              out_pv_q;
	logic [WORD_W-1:0] out_val_q;
	logic              out_done_q;

	logic              fire_s2;
	logic [MEM_AW-1:0] ra1, ra2;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] rd1, rd2;
	logic [WORD_W-1:0] sum;
	logic [LEN_W-1:0]  nxt;
	logic              done;

	assign fire_s2 = vld_s2 && (!out_vld_q || res.ready);
	assign pop     = head_vld && (!vld_s2 || fire_s2);

	// Read addresses: ADD reads B and C, the others read A and B
	assign ra1 = (head.kind == KIND_ADD) ? head.b : head.a;
	assign ra2 = (head.kind == KIND_ADD) ? head.c : head.b;

	// Operand select: same-edge write bypass, unwritten entries read as zero
	assign rd1 = byp1_s2 ? bypd_s2 : (ent1_s2 ? mem_rd1_s2 : '0);
	assign rd2 = byp2_s2 ? bypd_s2 : (ent2_s2 ? mem_rd2_s2 : '0);
	assign sum = rd1 + rd2;

	assign wr_en   = fire_s2 && ((item_s2.kind == KIND_LOAD) || (item_s2.kind == KIND_ADD));
	assign wr_data = (item_s2.kind == KIND_LOAD) ? WORD_W'(item_s2.imm) : sum;

	// Next pc and end of run
	always_comb begin
		nxt = {1'b0, pc_q} + LEN_W'(1);
		if ((item_s2.kind == KIND_JMPNE) && (rd1 != rd2)) begin
			nxt = LEN_W'(item_s2.imm[PC_W-1:0]);
		end
		done = (item_s2.kind == KIND_RET) || (nxt >= prog_len_q);
	end

	// Memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[item_s2.a] <= wr_data;
		end
		if (pop) begin
			mem_rd1_s2 <= mem[ra1];
			mem_rd2_s2 <= mem[ra2];
		end
	end

	// Execute stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			item_s2 <= head;
			ent1_s2 <= ent_vld_q[ra1];
			ent2_s2 <= ent_vld_q[ra2];
			byp1_s2 <= wr_en && (item_s2.a == ra1);
			byp2_s2 <= wr_en && (item_s2.a == ra2);
			bypd_s2 <= wr_data;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire_s2) begin
			out_pc_q   <= nxt[PC_W-1:0];
			out_pv_q   <= (item_s2.kind == KIND_PRINT);
			out_val_q  <= (item_s2.kind == KIND_PRINT) ? rd1 : '0;
			out_done_q <= done;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2     <= 1'b0;
			ent_vld_q  <= '0;
			pc_q       <= '0;
			prog_len_q <= LEN_RESET;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				prog_len_q <= cfg_wdata;
			end
			if (pop) begin
				vld_s2 <= 1'b1;
			end else if (fire_s2) begin
				vld_s2 <= 1'b0;
			end
			if (wr_en) begin
				ent_vld_q[item_s2.a] <= 1'b1;
			end
			if (fire_s2) begin
				pc_q      <= done ? '0 : nxt[PC_W-1:0];
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign res.valid       = out_vld_q;
	assign res.next_pc     = out_pc_q;
	assign res.print_valid = out_pv_q;
	assign res.print_value = $signed(out_val_q);
	assign res.run_done    = out_done_q;

endmodule

/* sim/bie_exec_checker.sv */
// Predicts and checks every result item of the bytecode instruction executor.
`timescale 1ns / 100ps

module bie_exec_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	bie_cmd_if                        cmd,
	bie_res_if                        res,
	input  logic                      cfg_we,
	input  logic [bie_pkg::LEN_W-1:0] cfg_wdata,
	output int                        mismatches,
	output int                        outstanding
);
	import bie_pkg::*;

	// One retired instruction as the block should report it
	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic              print_valid;
		logic [WORD_W-1:0] print_value;
		logic              run_done;
	} retire_t;

	logic [WORD_W-1:0] regs [MEM_DEPTH];
	logic [PC_W-1:0]   pc;
	logic [LEN_W-1:0]  prog_len;
	retire_t           retire_q [$];
	int                fail_cnt = 0;

	assign mismatches = fail_cnt;

	// Executes one instruction word on the shadow state and returns its result
	function automatic retire_t execute_word(input logic [WORD_W-1:0] w);
		retire_t          r;
		logic [OP_W-1:0]  op;
		int               ia;
		int               ib;
		int               ic;
		logic [LEN_W-1:0] nxt;
		logic             done;

		op   = w[3:0];
		ia   = int'(w[31:24]) % MEM_DEPTH;
		ib   = int'(w[23:16]) % MEM_DEPTH;
		ic   = int'(w[11:4]) % MEM_DEPTH;
		nxt  = LEN_W'(pc) + LEN_W'(1);
		done = 1'b0;
		r    = '0;
		case (op)
			OPC_LOAD: regs[ia] = WORD_W'(w[23:4]);
			OPC_ADD: regs[ia] = regs[ib] + regs[ic];
			OPC_JMPNE: begin
				if (regs[ia] != regs[ib])
					nxt = LEN_W'(w[15:4]);
			end
			OPC_PRINT: begin
				r.print_valid = 1'b1;
				r.print_value = regs[ia];
			end
			OPC_RET: done = 1'b1;
			default: ;
		endcase
		// pc+1 is compared at 13 bits, so 4095+1 still counts as 4096 here
		if (nxt >= prog_len)
			done = 1'b1;
		pc         = done ? '0 : nxt[PC_W-1:0];
		r.next_pc  = nxt[PC_W-1:0];
		r.run_done = done;
		return r;
	endfunction

	// Shadow state update on accepted items, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		retire_t want;

		if (!arst_n) begin
			for (int i = 0; i < MEM_DEPTH; i++)
				regs[i] = '0;
			pc       = '0;
			prog_len = LEN_RESET;
			retire_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				prog_len = cfg_wdata;
			if (cmd.valid && cmd.ready)
				retire_q.push_back(execute_word(cmd.instruction_word));
			if (res.valid && res.ready) begin
				if (retire_q.size() == 0) begin
					$error("result item with none expected: next_pc %0d", res.next_pc);
					fail_cnt++;
				end else begin
					want = retire_q.pop_front();
					if (res.next_pc !== want.next_pc) begin
						$error("next_pc: expected %0d, got %0d", want.next_pc, res.next_pc);
						fail_cnt++;
					end
					if (res.print_valid !== want.print_valid) begin
						$error("print_valid: expected %0d, got %0d",
							want.print_valid, res.print_valid);
						fail_cnt++;
					end
					if (res.print_value !== want.print_value) begin
						$error("print_value: expected %0d, got %0d",
							$signed(want.print_value), res.print_value);
						fail_cnt++;
					end
					if (res.run_done !== want.run_done) begin
						$error("run_done: expected %0d, got %0d", want.run_done, res.run_done);
						fail_cnt++;
					end
				end
			end
			outstanding <= retire_q.size();
		end
	end

endmodule

/* sim/bytecode_instruction_executor_tb.sv */
// Stimulus, clock, reset and verdict for the bytecode instruction executor.
`timescale 1ns / 100ps

module bytecode_instruction_executor_tb;
	import bie_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 153;

	// Opcodes the block does not decode
	localparam logic [OP_W-1:0] OPC_UNUSED_LO = 4'd5;
	localparam logic [OP_W-1:0] OPC_UNUSED_HI = 4'd15;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;
	logic             ret_ready = 1'b0;
	logic             gap_en    = 1'b0;
	logic             stall_en  = 1'b0;
	int               stall_left   = 0;
	int               quiet_cycles = 0;
	int               mismatches;
	int               outstanding;

	bie_cmd_if instr_ch();
	bie_res_if retire_ch();

	assign retire_ch.ready = ret_ready;

	bytecode_instruction_executor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (instr_ch),
		.res      (retire_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	bie_exec_checker exec_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (instr_ch),
		.res        (retire_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// Result side: ready drops in random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			ret_ready  <= 1'b0;
		end else if (stall_en && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 16);
			ret_ready  <= 1'b0;
		end else begin
			ret_ready <= 1'b1;
		end
	end

	// Watchdog: too long without any item moving
	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (retire_ch.valid && retire_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [WORD_W-1:0] pack_instr(input logic [OP_W-1:0] op,
			input logic [7:0] a, input logic [7:0] b, input logic [11:0] f);
		return {a, b, f, op};
	endfunction

	function automatic logic [WORD_W-1:0] pack_load(input logic [7:0] a,
			input logic [IMM_W-1:0] imm);
		return {a, imm, OPC_LOAD};
	endfunction

	// Mostly a few low registers so values collide and depend on each other
	function automatic logic [7:0] pick_reg();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom);
		return 8'($urandom_range(0, 7));
	endfunction

	// Offer one item, with an optional gap first; returns at its acceptance
	task automatic issue(input logic [WORD_W-1:0] w);
		if (gap_en && $urandom_range(0, 5) == 0) begin
			instr_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		instr_ch.valid           <= 1'b1;
		instr_ch.instruction_word <= w;
		@(posedge clk);
		while (!instr_ch.ready)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has come back
	task automatic await_retired();
		instr_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_length(input logic [LEN_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [LEN_W-1:0] len;
		logic [7:0]       ra;
		logic [7:0]       rb;
		int               sel;

		instr_ch.valid            <= 1'b0;
		instr_ch.instruction_word <= '0;
		repeat (7) @(posedge clk);
		arst_n   <= 1'b1;
		gap_en   <= 1'b1;
		stall_en <= 1'b1;
		@(posedge clk);

		// Directed: reset length of 7, runs end by length and by RET
		issue(pack_load(8'd0, 20'hfffff));
		issue(pack_load(8'd255, 20'h00001));
		issue(pack_load(8'd1, 20'h00000));
		issue(pack_instr(OPC_ADD, 8'd2, 8'd0, 12'hfff));  // C taken from low 8 bits
		issue(pack_instr(OPC_PRINT, 8'd2, 8'd0, 12'h000));
		issue(pack_instr(OPC_JMPNE, 8'd0, 8'd0, 12'h123)); // equal, falls through
		issue(pack_instr(OPC_ADD, 8'd3, 8'd2, 12'h002));
		issue(pack_instr(OPC_RET, 8'hff, 8'hff, 12'hfff));
		issue(pack_instr(OPC_UNUSED_HI, 8'hff, 8'hff, 12'hfff));
		issue(pack_instr(OPC_UNUSED_LO, 8'h00, 8'h00, 12'h000));
		issue(pack_instr(OPC_PRINT, 8'd255, 8'd0, 12'h000));
		await_retired();

		// pc wraps from 4095 and ends the run at length 4096
		set_length(13'd4096);
		issue(pack_instr(OPC_JMPNE, 8'd0, 8'd1, 12'hfff));
		issue(pack_instr(OPC_PRINT, 8'd0, 8'd0, 12'h000));
		issue(pack_instr(OPC_JMPNE, 8'd0, 8'd1, 12'hfff));
		issue(pack_instr(OPC_JMPNE, 8'd0, 8'd1, 12'h000));
		await_retired();

		// Past the largest length the wrap does not end the run
		set_length(13'd8191);
		issue(pack_instr(OPC_JMPNE, 8'd0, 8'd1, 12'hfff));
		issue(pack_instr(OPC_UNUSED_LO, 8'h00, 8'h00, 12'h000));
		await_retired();

		// Zero length: every step ends the run
		set_length(13'd0);
		issue(pack_load(8'd4, 20'h80000));
		issue(pack_instr(OPC_PRINT, 8'd4, 8'd0, 12'h000));
		await_retired();

		set_length(13'd1);
		issue(pack_instr(OPC_ADD, 8'd5, 8'd4, 12'h004));
		issue(pack_instr(OPC_PRINT, 8'd5, 8'd0, 12'h000));
		await_retired();

		// Random programs, one program length per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: len = 13'd16;
				1: len = LEN_W'($urandom_range(1, 64));
				2: len = 13'd4096;
				3: len = 13'd1;
				4: len = 13'd8191;
				5: len = 13'd0;
				6: len = LEN_W'($urandom_range(1, 4096));
				7: len = 13'd7;
				8: len = LEN_W'($urandom_range(2, 12));
				default: len = 13'd4096;
			endcase
			set_length(len);
			// no idling at all in the closing phase
			gap_en   <= (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			stall_en <= (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				ra  = pick_reg();
				rb  = pick_reg();
				sel = $urandom_range(0, 99);
				if (sel < 8)
					issue(pack_load(ra, IMM_W'($urandom_range(0, 3))));
				else if (sel < 25)
					issue(pack_load(ra, IMM_W'($urandom)));
				else if (sel < 50)
					issue(pack_instr(OPC_ADD, ra, rb, {4'($urandom), pick_reg()}));
				else if (sel < 60)
					issue(pack_instr(OPC_JMPNE, ra, rb, 12'($urandom_range(0, 15))));
				else if (sel < 70)
					issue(pack_instr(OPC_JMPNE, ra, rb, 12'($urandom)));
				else if (sel < 85)
					issue(pack_instr(OPC_PRINT, ra, 8'($urandom), 12'($urandom)));
				else if (sel < 90)
					issue(pack_instr(OPC_RET, 8'($urandom), 8'($urandom), 12'($urandom)));
				else
					issue({28'($urandom), 4'($urandom_range(OPC_UNUSED_LO, OPC_UNUSED_HI))});
				// occasional full drain in the middle of a phase
				if ($urandom_range(0, 199) == 0)
					await_retired();
			end
			await_retired();
		end

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* bytecode_instruction_executor.f */
sv/bie_pkg.sv
sv/bie_ifs.sv
sv/bie_front.sv
sv/bie_back.sv
sv/bytecode_instruction_executor.sv
sim/bie_exec_checker.sv
sim/bytecode_instruction_executor_tb.sv
